>>> sv/frsnl_pkg.sv
// Shared types and constants for the fresnel reflectance pipeline.
// No dependencies; imported by frsnl_front, frsnl_mid, frsnl_tail and the top level.
package frsnl_pkg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [17:0] TWO_Q16 = 18'h20000;
    localparam logic [15:0] ONE_Q12 = 16'd4096;

    // divider for 1 - sin2T, square root, Fresnel ratio dividers
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 33;
    localparam int RT_W   = 17;
    localparam int FNUM_W = 51;
    localparam int FDEN_W = 35;
    localparam int RAT_W  = 18;

    typedef struct packed {
        logic [16:0] cmag;
        logic        csign;
        logic [15:0] n1;
        logic [15:0] n2;
        logic        ent;
        logic        tir;
        logic        dega;
    } geom_t;

    typedef struct packed {
        logic ent;
        logic tir;
        logic dega;
        logic dzero;
        logic sat1;
    } flag_t;

    typedef struct packed {
        logic        ent;
        logic        deg;
        logic        tir;
        logic [16:0] refl;
    } res_t;

endpackage

>>> sv/frsnl_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Does not use frsnl_pkg; fully parameterized.
module frsnl_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 33,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          valid_reg [QW];
    logic [NW-1:0] rem_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic          v_in;
        logic [NW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic [CW-1:0] trial;
        logic [CW-1:0] rext;
        logic          ge;
        logic [QW-1:0] q_next;
        logic [NW-1:0] rem_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = num;
            assign q_in = '0;
            assign d_in = den;
            assign s_in = side_in;
        end else begin : g_rest
            assign v_in = valid_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign q_in = quo_reg[j-1];
            assign d_in = den_reg[j-1];
            assign s_in = side_reg[j-1];
        end

        assign trial = CW'(d_in) << B;
        assign rext  = CW'(r_in);
        assign ge    = rext >= trial;

        always_comb begin
            q_next    = q_in;
            q_next[B] = ge;
            rem_next  = ge ? NW'(rext - trial) : r_in;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= q_next;
                den_reg[j]  <= d_in;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

>>> sv/frsnl_sqrt.sv
// Pipelined floor square root, one root bit per stage, with a sideband.
// Fully parameterized; no package use.
module frsnl_sqrt #(
    parameter int IW = 33,
    parameter int RW = 17,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [IW-1:0] val,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [RW-1:0] root,
    output logic [SW-1:0] side_out
);
    localparam int TW = (2 * RW + 1 > IW) ? 2 * RW + 1 : IW;

    logic          valid_reg [RW];
    logic [IW-1:0] rem_reg   [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [SW-1:0] side_reg  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;
        logic          v_in;
        logic [IW-1:0] r_in;
        logic [RW-1:0] t_in;
        logic [SW-1:0] s_in;
        logic [TW-1:0] trial;
        logic [TW-1:0] rext;
        logic          ge;
        logic [RW-1:0] t_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = val;
            assign t_in = '0;
            assign s_in = side_in;
        end else begin : g_rest
            assign v_in = valid_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign t_in = root_reg[j-1];
            assign s_in = side_reg[j-1];
        end

        // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
        assign trial = (TW'(t_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign rext  = TW'(r_in);
        assign ge    = rext >= trial;

        always_comb begin
            t_next    = t_in;
            t_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= ge ? IW'(rext - trial) : r_in;
                root_reg[j] <= t_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

>>> sv/frsnl_front.sv
// Front stages: dot product, entering test, cosI, 1 - cosI^2, TIR test and
// the numerator/denominator for 1 - sin2T. Depends on frsnl_pkg.
module frsnl_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [15:0]        dir_x,
    input  logic signed [15:0]        dir_y,
    input  logic signed [15:0]        dir_z,
    input  logic signed [15:0]        normal_x,
    input  logic signed [15:0]        normal_y,
    input  logic signed [15:0]        normal_z,
    input  logic [15:0]               refractive_index,
    input  logic [14:0]               epsilon,
    output logic                      out_valid,
    output logic [frsnl_pkg::NUM_W-1:0] num,
    output logic [frsnl_pkg::DEN_W-1:0] den,
    output frsnl_pkg::geom_t          geom
);
    import frsnl_pkg::*;

    localparam int SH = 2 * FRAC_BITS - 16;
    localparam int TW = (15 + FRAC_BITS > 34) ? 15 + FRAC_BITS + 1 : 35;

    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic               e_valid_reg, f_valid_reg, g_valid_reg;
    logic signed [31:0] a_p0_reg, a_p1_reg, a_p2_reg;
    logic [15:0]        a_idx_reg, b_idx_reg;
    logic signed [33:0] b_dot_reg;
    geom_t              c_geom_reg, d_geom_reg, e_geom_reg, f_geom_reg, g_geom_reg;
    logic [32:0]        d_csq_reg;
    logic [31:0]        d_n1sq_reg, d_n2sq_reg, e_n1sq_reg, e_n2sq_reg, f_n2sq_reg;
    logic [32:0]        e_s_reg;
    logic [63:0]        f_lhs_reg;
    logic [63:0]        g_num_reg;
    logic [31:0]        g_den_reg;

    // stage C logic
    logic signed [33:0] m_neg;
    logic signed [33:0] m_sel;
    logic               ent;
    logic [33:0]        mag;
    logic [33:0]        magsh;
    geom_t              c_geom_next;

    // stage G logic
    logic [63:0]        rhs;
    geom_t              g_geom_next;

    always_comb begin
        m_neg = -b_dot_reg;
        ent   = !m_neg[33] && (TW'(m_neg[32:0]) > (TW'(epsilon) << FRAC_BITS));
        m_sel = ent ? m_neg : b_dot_reg;
        mag   = m_sel[33] ? 34'(-m_sel) : 34'(m_sel);
        magsh = mag >> SH;
        c_geom_next.cmag  = (magsh > 34'(ONE_Q16)) ? ONE_Q16 : magsh[16:0];
        c_geom_next.csign = m_sel[33];
        c_geom_next.n1    = ent ? ONE_Q12 : b_idx_reg;
        c_geom_next.n2    = ent ? b_idx_reg : ONE_Q12;
        c_geom_next.ent   = ent;
        c_geom_next.tir   = 1'b0;
        c_geom_next.dega  = 1'b0;
    end

    always_comb begin
        rhs              = {f_n2sq_reg, 32'b0};
        g_geom_next      = f_geom_reg;
        g_geom_next.tir  = f_lhs_reg > rhs;
        g_geom_next.dega = f_n2sq_reg == 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_p0_reg   <= 32'(dir_x) * 32'(normal_x);
            a_p1_reg   <= 32'(dir_y) * 32'(normal_y);
            a_p2_reg   <= 32'(dir_z) * 32'(normal_z);
            a_idx_reg  <= refractive_index;

            b_dot_reg  <= 34'(a_p0_reg) + 34'(a_p1_reg) + 34'(a_p2_reg);
            b_idx_reg  <= a_idx_reg;

            c_geom_reg <= c_geom_next;

            d_csq_reg  <= 33'({17'b0, c_geom_reg.cmag} * {17'b0, c_geom_reg.cmag});
            d_n1sq_reg <= {16'b0, c_geom_reg.n1} * {16'b0, c_geom_reg.n1};
            d_n2sq_reg <= {16'b0, c_geom_reg.n2} * {16'b0, c_geom_reg.n2};
            d_geom_reg <= c_geom_reg;

            e_s_reg    <= 33'h1_0000_0000 - d_csq_reg;
            e_n1sq_reg <= d_n1sq_reg;
            e_n2sq_reg <= d_n2sq_reg;
            e_geom_reg <= d_geom_reg;

            // s is 2^32 only when cosI is zero
            f_lhs_reg  <= e_s_reg[32] ? {e_n1sq_reg, 32'b0}
                                      : {32'b0, e_n1sq_reg} * {32'b0, e_s_reg[31:0]};
            f_n2sq_reg <= e_n2sq_reg;
            f_geom_reg <= e_geom_reg;

            g_num_reg  <= rhs - f_lhs_reg;
            g_den_reg  <= f_n2sq_reg;
            g_geom_reg <= g_geom_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign num       = g_num_reg;
    assign den       = g_den_reg;
    assign geom      = g_geom_reg;

endmodule

>>> sv/frsnl_mid.sv
// Middle stages: Fresnel numerators and denominators from n1, n2, cosI, cosT,
// magnitudes, saturation and zero checks. Depends on frsnl_pkg.
module frsnl_mid (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  frsnl_pkg::geom_t           geom,
    input  logic [frsnl_pkg::RT_W-1:0] cos_t,
    output logic                       out_valid,
    output logic [frsnl_pkg::FNUM_W-1:0] num1,
    output logic [frsnl_pkg::FDEN_W-1:0] den1,
    output logic [frsnl_pkg::FNUM_W-1:0] num2,
    output logic [frsnl_pkg::FDEN_W-1:0] den2,
    output frsnl_pkg::flag_t           flags,
    output logic                       sat2
);
    import frsnl_pkg::*;

    logic               h_valid_reg, i_valid_reg, j_valid_reg;
    logic signed [34:0] h_n1c_reg, h_n2c_reg;
    logic [33:0]        h_n2ct_reg, h_n1ct_reg;
    geom_t              h_geom_reg, i_geom_reg;
    logic signed [35:0] i_d1_reg, i_e1_reg, i_d2_reg, i_e2_reg;
    logic [34:0]        j_a1_reg, j_b1_reg, j_a2_reg, j_b2_reg;
    flag_t              j_flags_reg;
    logic               j_sat2_reg;

    logic signed [17:0] cs;
    logic [34:0]        a1, b1, a2, b2;
    flag_t              j_flags_next;

    always_comb begin
        cs = geom.csign ? -$signed({1'b0, geom.cmag}) : $signed({1'b0, geom.cmag});
    end

    always_comb begin
        a1 = i_e1_reg[35] ? 35'(-i_e1_reg) : 35'(i_e1_reg);
        b1 = i_d1_reg[35] ? 35'(-i_d1_reg) : 35'(i_d1_reg);
        a2 = i_e2_reg[35] ? 35'(-i_e2_reg) : 35'(i_e2_reg);
        b2 = i_d2_reg[35] ? 35'(-i_d2_reg) : 35'(i_d2_reg);
        j_flags_next.ent   = i_geom_reg.ent;
        j_flags_next.tir   = i_geom_reg.tir;
        j_flags_next.dega  = i_geom_reg.dega;
        j_flags_next.dzero = (b1 == 35'd0) || (b2 == 35'd0);
        j_flags_next.sat1  = {1'b0, a1} > {b1, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
        end else if (en) begin
            h_valid_reg <= in_valid;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_n1c_reg   <= 35'(cs) * $signed({19'b0, geom.n1});
            h_n2c_reg   <= 35'(cs) * $signed({19'b0, geom.n2});
            h_n2ct_reg  <= {18'b0, geom.n2} * {17'b0, cos_t};
            h_n1ct_reg  <= {18'b0, geom.n1} * {17'b0, cos_t};
            h_geom_reg  <= geom;

            i_d1_reg    <= 36'(h_n1c_reg) + $signed({2'b0, h_n2ct_reg});
            i_e1_reg    <= 36'(h_n1c_reg) - $signed({2'b0, h_n2ct_reg});
            i_d2_reg    <= 36'(h_n2c_reg) + $signed({2'b0, h_n1ct_reg});
            i_e2_reg    <= 36'(h_n2c_reg) - $signed({2'b0, h_n1ct_reg});
            i_geom_reg  <= h_geom_reg;

            j_a1_reg    <= a1;
            j_b1_reg    <= b1;
            j_a2_reg    <= a2;
            j_b2_reg    <= b2;
            j_flags_reg <= j_flags_next;
            j_sat2_reg  <= {1'b0, a2} > {b2, 1'b0};
        end
    end

    assign out_valid = j_valid_reg;
    assign num1      = {j_a1_reg, 16'b0};
    assign den1      = j_b1_reg;
    assign num2      = {j_a2_reg, 16'b0};
    assign den2      = j_b2_reg;
    assign flags     = j_flags_reg;
    assign sat2      = j_sat2_reg;

endmodule

>>> sv/frsnl_tail.sv
// Final stage: squares of the two ratios, average with rounding, saturation
// and the special-case overrides. Depends on frsnl_pkg.
module frsnl_tail (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [frsnl_pkg::RAT_W-1:0] q1,
    input  logic [frsnl_pkg::RAT_W-1:0] q2,
    input  frsnl_pkg::flag_t            flags,
    input  logic                        sat2,
    output logic                        out_valid,
    output frsnl_pkg::res_t             res
);
    import frsnl_pkg::*;

    logic        k_valid_reg;
    logic [35:0] k_sq1_reg, k_sq2_reg;
    flag_t       k_flags_reg;

    logic [17:0] r1, r2;
    logic [36:0] sum;
    logic [19:0] rnd;
    logic        deg;

    assign r1 = flags.sat1 ? TWO_Q16 : q1;
    assign r2 = sat2 ? TWO_Q16 : q2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (en) begin
            k_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_sq1_reg   <= {18'b0, r1} * {18'b0, r2 ^ r2 ^ r1};
            k_sq2_reg   <= {18'b0, r2} * {18'b0, r2};
            k_flags_reg <= flags;
        end
    end

    always_comb begin
        sum      = 37'(k_sq1_reg) + 37'(k_sq2_reg);
        rnd      = 20'((sum + 37'h1_0000) >> 17);
        deg      = !k_flags_reg.tir && (k_flags_reg.dega || k_flags_reg.dzero);
        res.ent  = k_flags_reg.ent;
        res.tir  = k_flags_reg.tir;
        res.deg  = deg;
        if (k_flags_reg.tir || deg || (rnd > 20'(ONE_Q16))) begin
            res.refl = ONE_Q16;
        end else begin
            res.refl = rnd[16:0];
        end
    end

    assign out_valid = k_valid_reg;

endmodule

>>> sv/fresnel_reflectance_core.sv
// Fresnel reflectance of a dielectric surface, fully pipelined.
// Instantiates frsnl_front, frsnl_div, frsnl_sqrt, frsnl_mid, frsnl_tail.
//
// Usage:
//   Input words carry a Q1.14 ray direction, a Q1.14 surface normal and a
//   Q4.12 refractive index on s_tdata. Each accepted word produces exactly
//   one output word: Q1.16 reflectance on m_tdata and the flags
//   total_reflection, degenerate, entering on m_tuser.
//   epsilon is written through cfg_we/cfg_wdata while the block is idle.
// Throughput: one word per cycle, sustained while the skid buffer is empty.
// Pipeline: from input acceptance to m_tvalid a word passes 7 front stages,
//   33 stages of the 1 - sin2T divider, 17 square-root stages, 3 stages of
//   Fresnel terms, 18 stages of the ratio dividers, 1 squaring stage and the
//   output register.
// Reset: aresetn low clears all valid bits, holds s_tready low and sets
//   epsilon to 1.
// Stall: an output register plus a one-word skid buffer sit at the end; the
//   pipeline keeps accepting while the output word waits, and freezes as a
//   whole only once the skid buffer holds a word. s_tready comes from a register.
module fresnel_reflectance_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [14:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, refractive_index
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // reflectance[16:0], zero pad[23:17]
    output logic [23:0]  m_tdata,
    // total_reflection, degenerate, entering
    output logic [2:0]   m_tuser
);
    import frsnl_pkg::*;

    logic [14:0] eps_reg;
    logic        en;

    logic               fr_valid;
    logic [NUM_W-1:0]   fr_num;
    logic [DEN_W-1:0]   fr_den;
    geom_t              fr_geom;

    logic               dv_valid;
    logic [QUO_W-1:0]   dv_quo;
    geom_t              dv_geom;

    logic               sq_valid;
    logic [RT_W-1:0]    sq_root;
    geom_t              sq_geom;

    logic               md_valid;
    logic [FNUM_W-1:0]  md_num1, md_num2;
    logic [FDEN_W-1:0]  md_den1, md_den2;
    flag_t              md_flags;
    logic               md_sat2;

    logic               r1_valid;
    logic [RAT_W-1:0]   r1_quo, r2_quo;
    flag_t              r1_flags;
    logic               r2_sat2;

    logic               p_valid;
    res_t               p_res;

    logic               out_valid_reg, skid_valid_reg;
    res_t               out_res_reg, skid_res_reg;
    logic               out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= 15'd1;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en && aresetn;

    frsnl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (s_tvalid && en),
        .dir_x            ($signed(s_tdata[15:0])),
        .dir_y            ($signed(s_tdata[31:16])),
        .dir_z            ($signed(s_tdata[47:32])),
        .normal_x         ($signed(s_tdata[63:48])),
        .normal_y         ($signed(s_tdata[79:64])),
        .normal_z         ($signed(s_tdata[95:80])),
        .refractive_index (s_tdata[111:96]),
        .epsilon          (eps_reg),
        .out_valid        (fr_valid),
        .num              (fr_num),
        .den              (fr_den),
        .geom             (fr_geom)
    );

    frsnl_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W), .SW($bits(geom_t))) u_div_cost (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .num       (fr_num),
        .den       (fr_den),
        .side_in   (fr_geom),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .side_out  (dv_geom)
    );

    frsnl_sqrt #(.IW(QUO_W), .RW(RT_W), .SW($bits(geom_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .val       (dv_quo),
        .side_in   (dv_geom),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_geom)
    );

    frsnl_mid u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .geom      (sq_geom),
        .cos_t     (sq_root),
        .out_valid (md_valid),
        .num1      (md_num1),
        .den1      (md_den1),
        .num2      (md_num2),
        .den2      (md_den2),
        .flags     (md_flags),
        .sat2      (md_sat2)
    );

    frsnl_div #(.NW(FNUM_W), .DW(FDEN_W), .QW(RAT_W), .SW($bits(flag_t))) u_div_per (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (md_valid),
        .num       (md_num1),
        .den       (md_den1),
        .side_in   (md_flags),
        .out_valid (r1_valid),
        .quo       (r1_quo),
        .side_out  (r1_flags)
    );

    frsnl_div #(.NW(FNUM_W), .DW(FDEN_W), .QW(RAT_W), .SW(1)) u_div_par (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (md_valid),
        .num       (md_num2),
        .den       (md_den2),
        .side_in   (md_sat2),
        .out_valid (),
        .quo       (r2_quo),
        .side_out  (r2_sat2)
    );

    frsnl_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r1_valid),
        .q1        (r1_quo),
        .q2        (r2_quo),
        .flags     (r1_flags),
        .sat2      (r2_sat2),
        .out_valid (p_valid),
        .res       (p_res)
    );

    // output register with a one-word skid buffer
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= p_valid;
            end
        end else if (p_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : p_res;
        end else if (en && p_valid) begin
            skid_res_reg <= p_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_res_reg.refl};
    assign m_tuser  = {out_res_reg.ent, out_res_reg.deg, out_res_reg.tir};

endmodule

>>> sv/frsnl_checker.sv
// Port-level checks for fresnel_reflectance_core, attached by bind.
// Sees only the top-level ports; no package use.
module frsnl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [23:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_tir_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[16:0] == 17'h10000 && !m_tuser[1])
        else $error("total reflection without full reflectance");

    a_deg_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[16:0] == 17'h10000)
        else $error("degenerate word without saturated reflectance");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:17] == 7'd0 && (!m_tdata[16] || m_tdata[15:0] == 16'd0))
        else $error("reflectance above 1.0");

endmodule

bind fresnel_reflectance_core frsnl_checker u_frsnl_checker (.*);

>>> tb/tb_fresnel_reflectance_checker.sv
// Checker for fresnel_reflectance_core: watches both stream channels, predicts
// each reflectance word from the input word and epsilon, compares in order.
// Depends on frsnl_pkg for the fixed-point constants.
module tb_fresnel_reflectance_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [14:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import frsnl_pkg::*;

    typedef struct packed {
        logic        ent;
        logic        deg;
        logic        tir;
        logic [16:0] refl;
    } shade_t;

    logic [14:0] eps_reg;
    shade_t      shade_q[$];

    function automatic logic [63:0] isqrt_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] ratio_q16(longint num, longint den);
        logic [63:0] a;
        logic [63:0] b;
        a = num < 0 ? -num : num;
        b = den < 0 ? -den : den;
        if (a > 2 * b) return 64'(TWO_Q16);
        return (a << 16) / b;
    endfunction

    function automatic shade_t predict_shade(logic [111:0] w, logic [14:0] eps);
        shade_t      r;
        longint      dot, m, n1, n2, c, mag, d1, d2, cT;
        logic [63:0] s, n1sq, n2sq, lhs, rhs, q, r1, r2, sum, refl;
        dot = longint'($signed(w[15:0])) * longint'($signed(w[63:48]))
            + longint'($signed(w[31:16])) * longint'($signed(w[79:64]))
            + longint'($signed(w[47:32])) * longint'($signed(w[95:80]));
        m = -dot;
        r = '0;
        r.ent = m > (longint'(eps) << 14);
        if (r.ent) begin
            n1 = 4096;
            n2 = longint'(w[111:96]);
        end else begin
            m = -m;
            n1 = longint'(w[111:96]);
            n2 = 4096;
        end
        // magnitude truncated to Q.16, then clamped to +-1.0
        mag = m < 0 ? -m : m;
        mag = mag >>> 12;
        c = m < 0 ? -mag : mag;
        if (c > 65536) c = 65536;
        if (c < -65536) c = -65536;
        s = (64'd1 << 32) - 64'(c * c);
        n1sq = 64'(n1 * n1);
        n2sq = 64'(n2 * n2);
        lhs = n1sq * s;
        rhs = n2sq << 32;
        r.refl = 17'h10000;
        if (lhs > rhs) begin
            r.tir = 1'b1;
            return r;
        end
        if (n2sq == 0) begin
            r.deg = 1'b1;
            return r;
        end
        q = (rhs - lhs) / n2sq;
        cT = longint'(isqrt_floor(q));
        d1 = n1 * c + n2 * cT;
        d2 = n2 * c + n1 * cT;
        if (d1 == 0 || d2 == 0) begin
            r.deg = 1'b1;
            return r;
        end
        r1 = ratio_q16(n1 * c - n2 * cT, d1);
        r2 = ratio_q16(n2 * c - n1 * cT, d2);
        sum = r1 * r1 + r2 * r2;
        refl = (sum + (64'd1 << 16)) >> 17;
        if (refl > 65536) refl = 65536;
        r.refl = refl[16:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        shade_t exp_w;
        shade_t got;
        if (!aresetn) begin
            eps_reg <= 15'd1;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_we) eps_reg <= cfg_wdata;
            if (s_tvalid && s_tready) shade_q.push_back(predict_shade(s_tdata, eps_reg));
            if (m_tvalid && m_tready) begin
                got = {m_tuser[2], m_tuser[1], m_tuser[0], m_tdata[16:0]};
                if (shade_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected word: %h", got);
                end else begin
                    exp_w = shade_q.pop_front();
                    if (got !== exp_w || m_tdata[23:17] !== 7'd0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: exp refl=%0d ent=%b deg=%b tir=%b, ",
                                      "got refl=%0d ent=%b deg=%b tir=%b"},
                                     exp_w.refl, exp_w.ent, exp_w.deg, exp_w.tir,
                                     got.refl, got.ent, got.deg, got.tir);
                    end
                end
            end
            pending <= shade_q.size();
        end
    end

endmodule

>>> tb/tb_fresnel_reflectance_core.sv
// Top of the fresnel_reflectance_core testbench: clock, reset, stimulus, verdict.
// Depends on fresnel_reflectance_core and tb_fresnel_reflectance_checker.
module tb_fresnel_reflectance_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [14:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [2:0]   m_tuser;
    int           fail_count;
    int           pending;
    bit           stim_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fresnel_reflectance_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    tb_fresnel_reflectance_checker chk (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'(-16384);
            1: return 16'd16384;
            2: return 16'($urandom);
            3: return 16'($signed(16'($urandom_range(0, 400))) - 200);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // unit-ish vectors along a random axis make the interesting paths reachable
    function automatic logic [111:0] rand_hit();
        logic [15:0] d[3];
        logic [15:0] n[3];
        logic [15:0] idx;
        int          ax;
        if ($urandom_range(0, 3) == 0) begin
            foreach (d[i]) d[i] = rand_comp();
            foreach (n[i]) n[i] = rand_comp();
        end else begin
            ax = $urandom_range(0, 2);
            foreach (d[i]) d[i] = 16'($urandom_range(0, 12000) - 6000);
            foreach (n[i]) n[i] = 16'($urandom_range(0, 200) - 100);
            d[ax] = $urandom_range(0, 1) ? 16'($urandom_range(8000, 16384))
                                         : 16'(-$urandom_range(8000, 16384));
            n[ax] = $urandom_range(0, 1) ? 16'd16384 : 16'(-16384);
        end
        case ($urandom_range(0, 4))
            0: idx = 16'($urandom);
            1: idx = 16'($urandom_range(0, 8));
            default: idx = 16'($urandom_range(3000, 12000));
        endcase
        return {idx, n[2], n[1], n[0], d[2], d[1], d[0]};
    endfunction

    task automatic send_word(logic [111:0] w);
        int n;
        n = $urandom_range(0, 3);
        if (n != 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_epsilon(logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random wait per word, plus one long hold-off after enough words
    initial begin
        int n;
        int got_cnt;
        got_cnt = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (got_cnt == 550) begin
                n = 300;
            end else begin
                n = $urandom_range(0, 3);
            end
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got_cnt++;
        end
    end

    initial begin
        logic [14:0] eps_set[4];
        logic [15:0] pos = 16'd16384;
        logic [15:0] neg = 16'(-16384);
        eps_set = '{15'd0, 15'd16384, 15'd1, 15'($urandom_range(1, 32767))};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: head-on entering, leaving, grazing, index extremes, zero index
        send_word({16'd6144, 16'd0, 16'd0, pos, 16'd0, 16'd0, neg});
        send_word({16'd6144, 16'd0, 16'd0, pos, 16'd0, 16'd0, pos});
        send_word({16'd0, 16'd0, 16'd0, pos, 16'd0, 16'd0, neg});
        send_word({16'd65535, 16'd0, 16'd0, pos, 16'd0, 16'd0, neg});
        send_word({16'd65535, 16'd0, pos, 16'd0, 16'd0, 16'd0, neg});
        send_word({16'd6144, 16'd0, pos, 16'd0, 16'd0, 16'd0, pos});
        send_word({16'd6144, 16'd0, 16'd0, pos, 16'd0, 16'd11585, 16'd11585});
        send_word({16'd4096, neg, neg, neg, neg, neg, neg});
        send_word({16'd4096, pos, pos, pos, neg, neg, neg});
        send_word({16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000});
        send_word({16'd1, 16'd0, 16'd0, neg, 16'd0, 16'd0, pos});
        send_word({16'd6144, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        send_word('1);
        drain_and_idle();
        foreach (eps_set[k]) begin
            set_epsilon(eps_set[k]);
            for (int i = 0; i < 450; i++) begin
                send_word(rand_hit());
            end
            drain_and_idle();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
